@@ design/phm_pkg.sv @@
// Package for the posed hit point merge unit: types and constants, including
// the Q30 polynomial coefficients of the quarter-wave sine. No dependencies.
`timescale 1ns / 1ps
package phm_pkg;

    localparam int SIN_W   = 17;   // signed Q1.15 with room for -32767
    localparam int COORD_W = 24;
    localparam int WGT_W   = 16;

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    localparam logic [WGT_W-1:0] WEIGHT_MAX = '1;

    localparam logic [15:0] RADIUS_RESET = 16'd100;

    // Odd polynomial coefficients of the quarter sine in Q30.
    localparam logic [30:0] TRIG_C1 = 31'd1686629713;
    localparam logic [30:0] TRIG_C3 = 31'd693598668;
    localparam logic [30:0] TRIG_C5 = 31'd85569304;
    localparam logic [30:0] TRIG_C7 = 31'd5026995;
    localparam logic [30:0] TRIG_C9 = 31'd172272;

    // Steps of one sine evaluation on the shared multiplier.
    localparam logic [2:0] STEP_SQUARE = 3'd0;
    localparam logic [2:0] STEP_C7     = 3'd1;
    localparam logic [2:0] STEP_C5     = 3'd2;
    localparam logic [2:0] STEP_C3     = 3'd3;
    localparam logic [2:0] STEP_C1     = 3'd4;
    localparam logic [2:0] STEP_SCALE  = 3'd5;
    localparam logic [2:0] STEP_ROUND  = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TRIG,
        ST_MUL,
        ST_SUM,
        ST_POS,
        ST_SCAN,
        ST_WAIT,
        ST_CMP,
        ST_DONE,
        ST_OUT
    } state_t;

endpackage

@@ design/phm_stream_if.sv @@
// Valid/ready stream interface carrying a payload of parameterized type.
// Depends on nothing.
`timescale 1ns / 1ps
interface phm_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ design/phm_ram.sv @@
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module phm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

@@ design/posed_hit_point_merge_unit.sv @@
// Posed hit point merge unit: transforms a sensor hit into world coordinates
// and merges it into a point table by a linear search of the stored entries.
// An add evaluates sine and cosine on the shared multiplier, then the transform, then checks
// the stored entries one by one: the hit is appended, or dropped when the table is full, if no entry
// matches, and merged into the first matching entry otherwise; a clear answers without a search.
// One item at a time; the next input is taken only after the result has been accepted.
// Reset (rst_n, asynchronous) empties the table and sets the radius to 100;
// the point memories need no clearing since only filled entries are read.
// Depends on phm_pkg, phm_stream_if and phm_ram.
`timescale 1ns / 1ps
module posed_hit_point_merge_unit
    import phm_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    phm_stream_if.sink   in_ch,
    phm_stream_if.source out_ch
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = AW + 1;

    state_t state_reg, state_next;

    logic [15:0] radius_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [2:0] step_reg, step_next;
    logic trig_sel_reg, trig_sel_next;

    logic signed [COORD_W-1:0] pose_x_reg, pose_y_reg;
    logic [15:0] angle_reg;
    logic signed [15:0] hx_reg, hy_reg;
    logic signed [SIN_W-1:0] sin_reg, cos_reg;
    logic [30:0] w_reg, poly_reg;
    logic signed [32:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [33:0] rx_reg, ry_reg;
    logic signed [COORD_W-1:0] wx_reg, wy_reg;
    logic [31:0] r2_reg;
    logic signed [COORD_W:0] dx_reg, dy_reg;
    logic [WGT_W-1:0] wgt_reg;
    logic [9:0] oidx_reg;
    logic onew_reg, odrop_reg;

    // Sine and cosine share one multiplier, evaluated step by step.
    logic [15:0] ang_c;
    logic [15:0] trig_ang;
    logic [14:0] trig_arg;
    logic [30:0] z_w, mul_a, mul_b, coef, prod_sh;
    logic [61:0] prod_w;
    logic [31:0] round_w;
    logic [15:0] trig_mag;
    logic signed [SIN_W-1:0] trig_val;

    assign ang_c    = angle_reg + 16'd16384;
    assign trig_ang = trig_sel_reg ? ang_c : angle_reg;
    assign trig_arg = trig_ang[14] ? (15'd16384 - {1'b0, trig_ang[13:0]})
                                   : {1'b0, trig_ang[13:0]};
    assign z_w      = {trig_arg, 16'd0};

    always_comb
    begin
        mul_a = w_reg;
        mul_b = poly_reg;
        coef  = TRIG_C1;
        unique case (step_reg)
            STEP_SQUARE:
            begin
                mul_a = z_w;
                mul_b = z_w;
            end
            STEP_C7:
            begin
                mul_b = TRIG_C9;
                coef  = TRIG_C7;
            end
            STEP_C5: coef = TRIG_C5;
            STEP_C3: coef = TRIG_C3;
            STEP_SCALE: mul_a = z_w;
            default:
            begin
            end
        endcase
    end

    assign prod_w   = mul_a * mul_b;
    assign prod_sh  = prod_w[60:30];
    assign round_w  = {1'b0, poly_reg} + 32'd16384;
    assign trig_mag = (round_w[31:15] > 17'd32767) ? 16'd32767 : round_w[30:15];
    assign trig_val = trig_ang[15] ? -$signed({1'b0, trig_mag}) : $signed({1'b0, trig_mag});

    // Memories.
    logic ram_we, ram_we_w;
    logic [AW-1:0] ram_addr;
    logic [COORD_W-1:0] rx_q, ry_q;
    logic [WGT_W-1:0] rw_q, ram_wgt;

    phm_ram #(.WIDTH(COORD_W), .DEPTH(TABLE_DEPTH)) u_ram_x (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(wx_reg), .rdata(rx_q));
    phm_ram #(.WIDTH(COORD_W), .DEPTH(TABLE_DEPTH)) u_ram_y (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(wy_reg), .rdata(ry_q));
    phm_ram #(.WIDTH(WGT_W), .DEPTH(TABLE_DEPTH)) u_ram_w (
        .clk(clk), .we(ram_we_w), .addr(ram_addr), .wdata(ram_wgt), .rdata(rw_q));

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {16'd0, radius_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else if (psel && penable && pwrite && paddr == 2'd0)
        begin
            radius_reg <= pwdata[15:0];
        end
    end

    logic signed [34:0] sumx_w, sumy_w;
    logic signed [COORD_W+1:0] posx_w, posy_w;
    logic signed [49:0] dx2_w, dy2_w;
    logic [49:0] d2_w;
    logic hit_w;

    assign sumx_w = 35'(p0_reg) - 35'(p1_reg) + 35'sd16384;
    assign sumy_w = 35'(p2_reg) + 35'(p3_reg) + 35'sd16384;
    assign posx_w = 26'(pose_x_reg) + 26'(rx_reg);
    assign posy_w = 26'(pose_y_reg) + 26'(ry_reg);
    assign dx2_w = dx_reg * dx_reg;
    assign dy2_w = dy_reg * dy_reg;
    assign d2_w = $unsigned(dx2_w) + $unsigned(dy2_w);
    assign hit_w = d2_w < 50'(r2_reg);

    function automatic logic signed [COORD_W-1:0] sat24(input logic signed [COORD_W+1:0] v);
        if (v > 26'sd8388607)
        begin
            return 24'sh7FFFFF;
        end
        else if (v < -26'sd8388608)
        begin
            return 24'sh800000;
        end
        return v[COORD_W-1:0];
    endfunction

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        step_next     = step_reg;
        trig_sel_next = trig_sel_reg;
        ram_we        = 1'b0;
        ram_we_w      = 1'b0;
        ram_addr      = idx_reg[AW-1:0];
        ram_wgt       = 16'd1;
        in_ch.ready  = 1'b0;
        out_ch.valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    idx_next      = '0;
                    step_next     = STEP_SQUARE;
                    trig_sel_next = 1'b0;
                    if (in_ch.data.func == FUNC_CLEAR)
                    begin
                        count_next = '0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_TRIG;
                    end
                end
            end
            ST_TRIG:
            begin
                // Sine first, then cosine, seven steps each.
                if (step_reg == STEP_ROUND)
                begin
                    step_next = STEP_SQUARE;
                    if (trig_sel_reg)
                    begin
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        trig_sel_next = 1'b1;
                    end
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_MUL:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_POS;
            ST_POS:  state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (idx_reg < count_reg)
                begin
                    state_next = ST_WAIT;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_WAIT: state_next = ST_CMP;
            ST_CMP:
            begin
                if (hit_w)
                begin
                    ram_we_w = 1'b1;
                    ram_wgt  = (rw_q == WEIGHT_MAX) ? rw_q : rw_q + 16'd1;
                    state_next = ST_OUT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_DONE:
            begin
                if (count_reg < CW'(TABLE_DEPTH))
                begin
                    ram_we = 1'b1;
                    ram_we_w = 1'b1;
                    ram_addr = count_reg[AW-1:0];
                    count_next = count_reg + 1'b1;
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_ch.valid = 1'b1;
                if (out_ch.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_ch.data.entry_index = oidx_reg;
    assign out_ch.data.is_new      = onew_reg;
    assign out_ch.data.weight      = wgt_reg;
    assign out_ch.data.dropped     = odrop_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            idx_reg      <= '0;
            step_reg     <= STEP_SQUARE;
            trig_sel_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            step_reg     <= step_next;
            trig_sel_reg <= trig_sel_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                pose_x_reg <= in_ch.data.pose_x;
                pose_y_reg <= in_ch.data.pose_y;
                angle_reg  <= in_ch.data.pose_angle;
                hx_reg     <= in_ch.data.point_x;
                hy_reg     <= in_ch.data.point_y;
                oidx_reg   <= '0;
                onew_reg   <= 1'b0;
                odrop_reg  <= 1'b0;
                wgt_reg    <= '0;
            end
            ST_TRIG:
            begin
                r2_reg <= radius_reg * radius_reg;
                unique case (step_reg)
                    STEP_SQUARE: w_reg <= prod_sh;
                    STEP_SCALE:  poly_reg <= prod_sh;
                    STEP_ROUND:
                    begin
                        if (trig_sel_reg)
                        begin
                            cos_reg <= trig_val;
                        end
                        else
                        begin
                            sin_reg <= trig_val;
                        end
                    end
                    default: poly_reg <= coef - prod_sh;
                endcase
            end
            ST_MUL:
            begin
                p0_reg <= hx_reg * cos_reg;
                p1_reg <= hy_reg * sin_reg;
                p2_reg <= hx_reg * sin_reg;
                p3_reg <= hy_reg * cos_reg;
            end
            ST_SUM:
            begin
                rx_reg <= 34'(sumx_w >>> 15);
                ry_reg <= 34'(sumy_w >>> 15);
            end
            ST_POS:
            begin
                wx_reg <= sat24(posx_w);
                wy_reg <= sat24(posy_w);
            end
            ST_WAIT:
            begin
                dx_reg <= 25'(wx_reg) - 25'($signed(rx_q));
                dy_reg <= 25'(wy_reg) - 25'($signed(ry_q));
            end
            ST_CMP:
            begin
                if (hit_w)
                begin
                    oidx_reg <= 10'(idx_reg);
                    wgt_reg  <= (rw_q == WEIGHT_MAX) ? rw_q : rw_q + 16'd1;
                end
            end
            ST_DONE:
            begin
                if (count_reg < CW'(TABLE_DEPTH))
                begin
                    oidx_reg <= 10'(count_reg);
                    onew_reg <= 1'b1;
                    wgt_reg  <= 16'd1;
                end
                else
                begin
                    odrop_reg <= 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end
endmodule

@@ design/phm_checker.sv @@
// Port-level checker for the posed hit point merge unit, bound to the top.
// Depends on the top level's port list.
`timescale 1ns / 1ps
module phm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       is_new,
    input logic       dropped,
    input logic [15:0] weight
);
    // One item at a time: no input while a result waits.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken while result pending");
    a_new_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(is_new && dropped)) else $error("new and dropped together");
    a_new_w: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_new) |-> weight == 16'd1) else $error("new weight not one");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid) else $error("result withdrawn");
endmodule

bind posed_hit_point_merge_unit phm_checker u_phm_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .is_new(out_ch.data.is_new), .dropped(out_ch.data.dropped),
    .weight(out_ch.data.weight));
